// ===== rtl/spct_pkg.sv =====
// Shared widths, op codes and the square-root-free normal search step for the
// shape pair collision test. No dependencies.
package spct_pkg;

    localparam int CoordW    = 24;
    localparam int SizeW     = 23;
    localparam int RadW      = 24;
    localparam int NormW     = 16;
    localparam int DiffW     = 25;
    localparam int MagW      = 25;
    localparam int SqW       = 50;
    localparam int RadSqW    = 48;
    localparam int SclW      = 15;
    localparam int SclSqW    = 30;
    localparam int QW        = 15;
    localparam int LenW      = 31;
    localparam int RhsShift  = 30;
    localparam int RhsW      = SclSqW + RhsShift;
    localparam int AccW      = 64;
    localparam int TW        = 48;
    localparam int NSteps    = 15;
    localparam int MaxShift  = 10;
    localparam int ShW       = 4;
    localparam int FrontStg  = 6;
    localparam int NStages   = FrontStg + NSteps + 1;

    typedef enum logic [2:0] {
        OP_PT_PT     = 3'd0,
        OP_PT_CIRC   = 3'd1,
        OP_CIRC_PT   = 3'd2,
        OP_CIRC_CIRC = 3'd3,
        OP_CIRC_RECT = 3'd4,
        OP_RECT_CIRC = 3'd5
    } t_op;

    // Running state of one normal component search: u = 2q, s = u*u*len2, t = u*len2.
    typedef struct packed {
        logic [AccW-1:0] s;
        logic [TW-1:0]   t;
        logic [QW-1:0]   q;
    } t_srch;

    // Result fields that ride along with the normal search.
    typedef struct packed {
        logic              hit;
        logic              nz;
        logic              neg_x;
        logic              neg_y;
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
    } t_carry;

    // One bit of the search: try q | 2^k, i.e. e = u + 2^(k+1) - 1, and keep it
    // when e*e*len2 <= rhs. All products are formed from shifts of s, t and len2.
    function automatic t_srch srch_step(t_srch cur, logic [LenW-1:0] len2,
                                        logic [RhsW-1:0] rhs, int k);
        logic [AccW-1:0] l64;
        logic [AccW-1:0] t64;
        logic [AccW-1:0] grow;
        logic [AccW-1:0] test;
        t_srch           nxt;
        l64  = AccW'(len2);
        t64  = AccW'(cur.t);
        grow = cur.s + (t64 << (k + 2)) + (l64 << (2 * k + 2));
        test = grow + l64 - (t64 << 1) - (l64 << (k + 2));
        nxt  = cur;
        if (test <= AccW'(rhs)) begin
            nxt.s = grow;
            nxt.t = TW'(t64 + (l64 << (k + 1)));
            nxt.q = cur.q | (QW'(1) << k);
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/shape_pair_collision_test.sv =====
// Top level of the shape pair collision test: a 22-stage pipeline.
// Depends on spct_pkg for widths, op codes and the normal search step.
//
// The block takes one shape pair per clock while the output side does not stall,
// and returns one result per pair, in order.
// The pipeline depth is set by the unit normal: each of the 15 result bits of the
// normal component search has a register stage of its own, behind six stages that
// form the differences, the clamp, the squared lengths and the prescale.
// A stall at the output holds the whole pipeline; nothing is dropped or repeated.
module shape_pair_collision_test (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [2:0]                           i_op,
    input  logic signed [spct_pkg::CoordW-1:0]   i_first_x,
    input  logic signed [spct_pkg::CoordW-1:0]   i_first_y,
    input  logic [spct_pkg::SizeW-1:0]           i_first_size_a,
    input  logic [spct_pkg::SizeW-1:0]           i_first_size_b,
    input  logic signed [spct_pkg::CoordW-1:0]   i_second_x,
    input  logic signed [spct_pkg::CoordW-1:0]   i_second_y,
    input  logic [spct_pkg::SizeW-1:0]           i_second_size_a,
    input  logic [spct_pkg::SizeW-1:0]           i_second_size_b,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_hit,
    output logic signed [spct_pkg::CoordW-1:0]   o_contact_x,
    output logic signed [spct_pkg::CoordW-1:0]   o_contact_y,
    output logic signed [spct_pkg::NormW-1:0]    o_normal_x,
    output logic signed [spct_pkg::NormW-1:0]    o_normal_y
);
    import spct_pkg::*;

    logic en;
    logic [NStages-1:0] r_vld;

    // Pipeline advances whenever the output register is free or being taken.
    assign en          = !r_vld[NStages-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NStages-2:0], i_in_valid};
        end
    end

    // Stage 1: register the pair and form both center differences.
    logic [2:0]               r1_op;
    logic signed [CoordW-1:0] r1_x1, r1_y1, r1_x2, r1_y2;
    logic [SizeW-1:0]         r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [DiffW-1:0]  r1_dx, r1_dy, r1_ndx, r1_ndy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op  <= i_op;
            r1_x1  <= i_first_x;
            r1_y1  <= i_first_y;
            r1_x2  <= i_second_x;
            r1_y2  <= i_second_y;
            r1_a1  <= i_first_size_a;
            r1_b1  <= i_first_size_b;
            r1_a2  <= i_second_size_a;
            r1_b2  <= i_second_size_b;
            r1_dx  <= DiffW'(i_first_x) - DiffW'(i_second_x);
            r1_dy  <= DiffW'(i_first_y) - DiffW'(i_second_y);
            r1_ndx <= DiffW'(i_second_x) - DiffW'(i_first_x);
            r1_ndy <= DiffW'(i_second_y) - DiffW'(i_first_y);
        end
    end

    // Stage 2: pick the test vector, radius and contact point for the op.
    logic signed [DiffW-1:0]  n2_vx, n2_vy;
    logic [RadW-1:0]          n2_r;
    logic [CoordW-1:0]        n2_cx, n2_cy;
    logic                     n2_eq;

    logic signed [DiffW-1:0]  r2_vx, r2_vy;
    logic [RadW-1:0]          r2_r;
    logic [CoordW-1:0]        r2_cx, r2_cy;
    logic                     r2_eq;
    logic [2:0]               r2_op;

    always_comb begin
        logic signed [DiffW-1:0] dsel_x, dsel_y, lim_x, lim_y, cl_x, cl_y;
        logic signed [DiffW:0]   base_x, base_y;
        dsel_x = r1_dx;
        dsel_y = r1_dy;
        lim_x  = DiffW'(r1_a2);
        lim_y  = DiffW'(r1_b2);
        base_x = (DiffW+1)'(r1_x2);
        base_y = (DiffW+1)'(r1_y2);
        if (r1_op == OP_RECT_CIRC) begin
            dsel_x = r1_ndx;
            dsel_y = r1_ndy;
            lim_x  = DiffW'(r1_a1);
            lim_y  = DiffW'(r1_b1);
            base_x = (DiffW+1)'(r1_x1);
            base_y = (DiffW+1)'(r1_y1);
        end
        // Nearest box point as an offset from the box center.
        cl_x = (dsel_x > lim_x) ? lim_x : ((dsel_x < -lim_x) ? -lim_x : dsel_x);
        cl_y = (dsel_y > lim_y) ? lim_y : ((dsel_y < -lim_y) ? -lim_y : dsel_y);

        n2_eq = (r1_dx == '0) && (r1_dy == '0);
        n2_vx = '0;
        n2_vy = '0;
        n2_r  = '0;
        n2_cx = r1_x1;
        n2_cy = r1_y1;
        case (r1_op)
            OP_PT_CIRC: begin
                n2_vx = r1_dx;
                n2_vy = r1_dy;
                n2_r  = RadW'(r1_a2);
            end
            OP_CIRC_PT: begin
                n2_vx = r1_ndx;
                n2_vy = r1_ndy;
                n2_r  = RadW'(r1_a1);
                n2_cx = r1_x2;
                n2_cy = r1_y2;
            end
            OP_CIRC_CIRC: begin
                n2_vx = r1_dx;
                n2_vy = r1_dy;
                n2_r  = RadW'(r1_a1) + RadW'(r1_a2);
                n2_cx = CoordW'((DiffW+1)'(r1_x2) + (DiffW+1)'(r1_dx >>> 1));
                n2_cy = CoordW'((DiffW+1)'(r1_y2) + (DiffW+1)'(r1_dy >>> 1));
            end
            OP_CIRC_RECT, OP_RECT_CIRC: begin
                n2_vx = cl_x - dsel_x;
                n2_vy = cl_y - dsel_y;
                n2_r  = (r1_op == OP_CIRC_RECT) ? RadW'(r1_a1) : RadW'(r1_a2);
                n2_cx = CoordW'(base_x + (DiffW+1)'(cl_x));
                n2_cy = CoordW'(base_y + (DiffW+1)'(cl_y));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_vx <= n2_vx;
            r2_vy <= n2_vy;
            r2_r  <= n2_r;
            r2_cx <= n2_cx;
            r2_cy <= n2_cy;
            r2_eq <= n2_eq;
            r2_op <= r1_op;
        end
    end

    // Stage 3: magnitudes and signs of the test vector.
    logic [MagW-1:0]   r3_ax, r3_ay;
    logic              r3_sx, r3_sy, r3_eq;
    logic [RadW-1:0]   r3_r;
    logic [CoordW-1:0] r3_cx, r3_cy;
    logic [2:0]        r3_op;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ax <= r2_vx[DiffW-1] ? MagW'(-r2_vx) : MagW'(r2_vx);
            r3_ay <= r2_vy[DiffW-1] ? MagW'(-r2_vy) : MagW'(r2_vy);
            r3_sx <= r2_vx[DiffW-1];
            r3_sy <= r2_vy[DiffW-1];
            r3_eq <= r2_eq;
            r3_r  <= r2_r;
            r3_cx <= r2_cx;
            r3_cy <= r2_cy;
            r3_op <= r2_op;
        end
    end

    // Stage 4: full-precision squares and the prescaled magnitudes.
    logic [SclW-1:0] n4_sax, n4_say;

    always_comb begin
        logic [MagW-1:0] m;
        logic [ShW-1:0]  sh;
        m  = (r3_ax > r3_ay) ? r3_ax : r3_ay;
        sh = '0;
        for (int i = MaxShift; i >= 0; i--) begin
            if ((m >> i) < MagW'(1 << SclW)) begin
                sh = ShW'(i);
            end
        end
        n4_sax = SclW'(r3_ax >> sh);
        n4_say = SclW'(r3_ay >> sh);
    end

    logic [SqW-1:0]    r4_ax2, r4_ay2;
    logic [RadSqW-1:0] r4_r2;
    logic [SclW-1:0]   r4_sax, r4_say;
    logic              r4_sx, r4_sy, r4_eq;
    logic [CoordW-1:0] r4_cx, r4_cy;
    logic [2:0]        r4_op;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ax2 <= SqW'(r3_ax) * SqW'(r3_ax);
            r4_ay2 <= SqW'(r3_ay) * SqW'(r3_ay);
            r4_r2  <= RadSqW'(r3_r) * RadSqW'(r3_r);
            r4_sax <= n4_sax;
            r4_say <= n4_say;
            r4_sx  <= r3_sx;
            r4_sy  <= r3_sy;
            r4_eq  <= r3_eq;
            r4_cx  <= r3_cx;
            r4_cy  <= r3_cy;
            r4_op  <= r3_op;
        end
    end

    // Stage 5: hit decision by squared distance; squares of prescaled magnitudes.
    logic n5_hit;

    always_comb begin
        logic [SqW:0] dist2;
        dist2 = (SqW+1)'(r4_ax2) + (SqW+1)'(r4_ay2);
        case (r4_op)
            OP_PT_PT:                                 n5_hit = r4_eq;
            OP_PT_CIRC, OP_CIRC_PT, OP_CIRC_CIRC,
            OP_CIRC_RECT, OP_RECT_CIRC:               n5_hit = dist2 <= (SqW+1)'(r4_r2);
            default:                                  n5_hit = 1'b0;
        endcase
    end

    logic              r5_hit, r5_sx, r5_sy;
    logic [SclSqW-1:0] r5_sqx, r5_sqy;
    logic [CoordW-1:0] r5_cx, r5_cy;
    logic [2:0]        r5_op;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hit <= n5_hit;
            r5_sqx <= SclSqW'(r4_sax) * SclSqW'(r4_sax);
            r5_sqy <= SclSqW'(r4_say) * SclSqW'(r4_say);
            r5_sx  <= r4_sx;
            r5_sy  <= r4_sy;
            r5_cx  <= r4_cx;
            r5_cy  <= r4_cy;
            r5_op  <= r4_op;
        end
    end

    // Stage 6: squared length for the normal and the search start values.
    t_carry          r_cr  [0:NSteps];
    t_srch           r_srx [0:NSteps];
    t_srch           r_sry [0:NSteps];
    logic [LenW-1:0] r_len [0:NSteps-1];
    logic [RhsW-1:0] r_rhx [0:NSteps-1];
    logic [RhsW-1:0] r_rhy [0:NSteps-1];

    always_ff @(posedge i_clk) begin
        logic [LenW-1:0] len2;
        logic            swap;
        len2 = LenW'(r5_sqx) + LenW'(r5_sqy);
        swap = (r5_op == OP_CIRC_PT) || (r5_op == OP_RECT_CIRC);
        if (en) begin
            r_len[0]    <= len2;
            r_rhx[0]    <= {r5_sqx, RhsShift'(0)};
            r_rhy[0]    <= {r5_sqy, RhsShift'(0)};
            r_srx[0]    <= '0;
            r_sry[0]    <= '0;
            r_cr[0].hit <= r5_hit;
            r_cr[0].nz  <= r5_hit && (len2 != '0) && (r5_op != OP_PT_PT);
            r_cr[0].neg_x <= r5_sx ^ swap;
            r_cr[0].neg_y <= r5_sy ^ swap;
            r_cr[0].cx  <= r5_cx;
            r_cr[0].cy  <= r5_cy;
        end
    end

    // Normal search: one result bit per stage, most significant first.
    for (genvar j = 0; j < NSteps; j++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srx[j+1] <= srch_step(r_srx[j], r_len[j], r_rhx[j], NSteps - 1 - j);
                r_sry[j+1] <= srch_step(r_sry[j], r_len[j], r_rhy[j], NSteps - 1 - j);
                r_cr[j+1]  <= r_cr[j];
            end
        end
        if (j < NSteps - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_len[j+1] <= r_len[j];
                    r_rhx[j+1] <= r_rhx[j];
                    r_rhy[j+1] <= r_rhy[j];
                end
            end
        end
    end

    // Output register: apply signs, zero everything on a miss.
    logic [NormW-1:0] n_nx, n_ny;

    always_comb begin
        logic [NormW-1:0] mx, my;
        mx   = NormW'(r_srx[NSteps].q);
        my   = NormW'(r_sry[NSteps].q);
        n_nx = '0;
        n_ny = '0;
        if (r_cr[NSteps].nz) begin
            n_nx = r_cr[NSteps].neg_x ? -mx : mx;
            n_ny = r_cr[NSteps].neg_y ? -my : my;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit       <= r_cr[NSteps].hit;
            o_contact_x <= r_cr[NSteps].hit ? r_cr[NSteps].cx : '0;
            o_contact_y <= r_cr[NSteps].hit ? r_cr[NSteps].cy : '0;
            o_normal_x  <= n_nx;
            o_normal_y  <= n_ny;
        end
    end

    // A miss carries no contact point and no normal.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_contact_x == '0 && o_contact_y == '0
                                     && o_normal_x == '0 && o_normal_y == '0))
        else $error("miss with nonzero contact or normal");

    // Normal components never exceed one in Q1.14.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384
                         && o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384))
        else $error("normal component out of range");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ===== tb/sv/shape_pair_collision_test_test.sv =====
// Self-checking testbench for the shape pair collision test pipeline.
// Depends on spct_pkg and shape_pair_collision_test; predicts each result in place.
module shape_pair_collision_test_test;
    timeunit 1ns;
    timeprecision 1ps;
    import spct_pkg::*;

    typedef struct {
        logic [2:0]         op;
        logic signed [23:0] x1, y1, x2, y2;
        logic [22:0]        a1, b1, a2, b2;
    } t_pair;

    typedef struct {
        logic               hit;
        logic signed [23:0] cx, cy;
        logic signed [15:0] nx, ny;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic o_in_ready, o_out_valid, o_hit;
    logic [2:0] i_op = '0;
    logic signed [23:0] i_first_x = '0, i_first_y = '0, i_second_x = '0, i_second_y = '0;
    logic [22:0] i_first_size_a = '0, i_first_size_b = '0;
    logic [22:0] i_second_size_a = '0, i_second_size_b = '0;
    logic signed [23:0] o_contact_x, o_contact_y;
    logic signed [15:0] o_normal_x, o_normal_y;

    t_pair    pending_pairs[$];
    t_contact expected_contacts[$];
    int  n_errors = 0;
    int  n_checked = 0;
    int  n_hits = 0;
    bit  gen_done = 1'b0;
    bit  calm = 1'b0;      // no idling in the last part of the run
    bit  hold_out = 1'b0;  // long receiver hold-off request
    bit  in_taken = 1'b0;  // the offered pair was transferred at the last rising edge
    int  in_gap = 0;
    int  out_gap = 0;
    int  hold_cnt = 0;

    shape_pair_collision_test dut (.*);

    always #1 i_clk = ~i_clk;

    // Magnitude of one normal component, found bit by bit exactly.
    function automatic longint unsigned unit_component(longint unsigned a,
                                                       longint unsigned len2);
        longint unsigned q, t, e, rhs;
        q = 0;
        rhs = (a * a) << 30;
        for (int k = 14; k >= 0; k--) begin
            t = q | (64'd1 << k);
            e = 2 * t - 1;
            if (e * e * len2 <= rhs) q = t;
        end
        return q;
    endfunction

    // Unit normal in Q1.14 with prescale of the larger magnitude below 2^15.
    function automatic void unit_normal(longint dx, longint dy,
                                        output longint nx, output longint ny);
        longint unsigned ax, ay, m, len2, qx, qy;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        m = ax > ay ? ax : ay;
        nx = 0;
        ny = 0;
        while (m >= 32768) begin
            m = m >> 1;
            ax = ax >> 1;
            ay = ay >> 1;
        end
        len2 = ax * ax + ay * ay;
        if (len2 == 0) return;
        qx = unit_component(ax, len2);
        qy = unit_component(ay, len2);
        nx = dx < 0 ? -longint'(qx) : longint'(qx);
        ny = dy < 0 ? -longint'(qy) : longint'(qy);
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Expected contact for one shape pair.
    function automatic t_contact predict_contact(t_pair p);
        t_contact r;
        longint x1, y1, x2, y2, px, py, ox, oy, dx, dy, qx, qy, rad, nx, ny;
        bit flip;
        x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
        r.hit = 0; r.cx = 0; r.cy = 0; r.nx = 0; r.ny = 0;
        nx = 0; ny = 0;
        flip = (p.op == OP_CIRC_PT) || (p.op == OP_RECT_CIRC);
        case (p.op)
            OP_PT_PT: begin
                if (x1 == x2 && y1 == y2) begin
                    r.hit = 1; r.cx = p.x1; r.cy = p.y1;
                end
            end
            OP_PT_CIRC, OP_CIRC_PT: begin
                px = flip ? x2 : x1; py = flip ? y2 : y1;
                ox = flip ? x1 : x2; oy = flip ? y1 : y2;
                rad = flip ? p.a1 : p.a2;
                dx = px - ox; dy = py - oy;
                if (dx * dx + dy * dy <= rad * rad) begin
                    r.hit = 1; r.cx = px; r.cy = py;
                    unit_normal(dx, dy, nx, ny);
                end
            end
            OP_CIRC_CIRC: begin
                dx = x1 - x2; dy = y1 - y2;
                rad = longint'(p.a1) + longint'(p.a2);
                if (dx * dx + dy * dy <= rad * rad) begin
                    r.hit = 1;
                    r.cx = x2 + (dx >>> 1);
                    r.cy = y2 + (dy >>> 1);
                    unit_normal(dx, dy, nx, ny);
                end
            end
            OP_CIRC_RECT, OP_RECT_CIRC: begin
                px = flip ? x2 : x1; py = flip ? y2 : y1;
                ox = flip ? x1 : x2; oy = flip ? y1 : y2;
                rad = flip ? p.a2 : p.a1;
                qx = ox + clamp_sym(px - ox, flip ? p.a1 : p.a2);
                qy = oy + clamp_sym(py - oy, flip ? p.b1 : p.b2);
                dx = qx - px; dy = qy - py;
                if (dx * dx + dy * dy <= rad * rad) begin
                    r.hit = 1; r.cx = qx; r.cy = qy;
                    unit_normal(dx, dy, nx, ny);
                end
            end
            default: ;
        endcase
        if (r.hit && flip) begin
            nx = -nx; ny = -ny;
        end
        r.nx = nx; r.ny = ny;
        return r;
    endfunction

    // Queue one pair for the driver.
    task automatic add_pair(logic [2:0] op, logic signed [23:0] x1, logic signed [23:0] y1,
                            logic [22:0] a1, logic [22:0] b1, logic signed [23:0] x2,
                            logic signed [23:0] y2, logic [22:0] a2, logic [22:0] b2);
        t_pair p;
        p.op = op; p.x1 = x1; p.y1 = y1; p.a1 = a1; p.b1 = b1;
        p.x2 = x2; p.y2 = y2; p.a2 = a2; p.b2 = b2;
        pending_pairs.push_back(p);
    endtask

    function automatic logic [22:0] rand_size();
        case ($urandom_range(0, 3))
            0: return 23'($urandom_range(0, 255));
            1: return 23'($urandom_range(0, 65535));
            2: return 23'($urandom);
            default: return '1;
        endcase
    endfunction

    // Random pair: mostly near each other so that hits are common.
    task automatic add_random_pair();
        logic signed [23:0] x1, y1, x2, y2;
        logic [22:0] a1, a2;
        int spread;
        x1 = 24'($urandom);
        y1 = 24'($urandom);
        a1 = rand_size();
        a2 = rand_size();
        spread = (1 << $urandom_range(0, 23)) - 1;
        if ($urandom_range(0, 9) == 0) begin
            x2 = 24'($urandom);
            y2 = 24'($urandom);
        end else begin
            // Keep the second centre close, clipping at the range edges.
            x2 = 24'(clamp_sym(longint'(x1) + $signed($urandom_range(0, 2 * spread))
                               - spread, 8388607));
            y2 = 24'(clamp_sym(longint'(y1) + $signed($urandom_range(0, 2 * spread))
                               - spread, 8388607));
            if (longint'(x2) - longint'(x1) > spread || longint'(x2) < -8388608) x2 = x1;
        end
        if ($urandom_range(0, 15) == 0) begin
            x2 = x1;
            y2 = y1;
        end
        add_pair(3'($urandom_range(0, 7)), x1, y1, a1, rand_size(), x2, y2, a2, rand_size());
    endtask

    // Stimulus: directed corners, then random pairs.
    initial begin
        for (int op = 0; op < 8; op++) begin
            add_pair(3'(op), 0, 0, 0, 0, 0, 0, 0, 0);
            add_pair(3'(op), 24'sh7FFFFF, 24'sh800000, '1, '1, 24'sh800000, 24'sh7FFFFF,
                     '1, '1);
        end
        add_pair(OP_PT_CIRC, 24'sd300, 24'sd400, 0, 0, 0, 0, 23'd500, 0);
        add_pair(OP_CIRC_PT, 0, 0, 23'd499, 0, 24'sd300, 24'sd400, 0, 0);
        add_pair(OP_CIRC_CIRC, -24'sd3, -24'sd5, 23'd2, 0, 0, 0, 23'd4, 0);
        add_pair(OP_CIRC_RECT, 24'sd10, 24'sd10, 23'd100, 0, 0, 0, 23'd20, 23'd20);
        add_pair(OP_RECT_CIRC, 0, 0, 23'd50, 23'd10, 24'sd60, 24'sd10, 23'd10, 0);
        add_pair(OP_CIRC_RECT, 24'sd1, -24'sd1, 0, '1, 0, 0, '1, '1);
        add_pair(OP_PT_PT, -24'sd1, 24'sd5, 0, 0, -24'sd1, 24'sd5, '1, '1);
        add_pair(OP_CIRC_CIRC, 24'sh7FFFFF, 24'sh7FFFFF, '1, 0, 24'sh800000, 24'sh800000, '1, 0);
        for (int i = 0; i < 1630; i++) begin
            // Pause the sender until the pipeline is empty once.
            if (i == 400) begin
                wait (pending_pairs.size() == 0 && expected_contacts.size() == 0);
            end
            if (i == 700) begin
                wait (pending_pairs.size() == 0);
                hold_out = 1'b1;
            end
            // The last stretch runs without idling on either side.
            if (i == 1400) begin
                wait (pending_pairs.size() == 0);
                calm = 1'b1;
            end
            add_random_pair();
        end
        gen_done = 1'b1;
    end

    // Notes whether the offered pair was transferred at this rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
    end

    // Driver: offers queued pairs with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    t_pair p;
                    p = pending_pairs.pop_front();
                    expected_contacts.push_back(predict_contact(p));
                    i_op <= p.op;
                    i_first_x <= p.x1; i_first_y <= p.y1;
                    i_first_size_a <= p.a1; i_first_size_b <= p.b1;
                    i_second_x <= p.x2; i_second_y <= p.y2;
                    i_second_size_a <= p.a2; i_second_size_b <= p.b2;
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 8);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side ready: random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_out && hold_cnt < 200) begin
                hold_cnt <= hold_cnt + 1;
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 8);
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_contacts.size() == 0) begin
                $display("%0t: unexpected result hit=%0b", $time, o_hit);
                n_errors++;
            end else begin
                t_contact e;
                e = expected_contacts.pop_front();
                n_checked++;
                if (e.hit) n_hits++;
                if (o_hit !== e.hit || o_contact_x !== e.cx || o_contact_y !== e.cy ||
                    o_normal_x !== e.nx || o_normal_y !== e.ny) begin
                    $display("%0t: expected hit=%0b c=(%0d,%0d) n=(%0d,%0d)", $time,
                             e.hit, e.cx, e.cy, e.nx, e.ny);
                    $display("%0t:   actual hit=%0b c=(%0d,%0d) n=(%0d,%0d)", $time,
                             o_hit, o_contact_x, o_contact_y, o_normal_x, o_normal_y);
                    n_errors++;
                end
            end
        end
    end

    // Reset, then wait for the drain and report.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (gen_done && pending_pairs.size() == 0 && !i_in_valid);
        wait (expected_contacts.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Checked %0d results (%0d hits) over all op codes, with stalls and gaps.",
                 n_checked, n_hits);
        if (n_errors == 0 && expected_contacts.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
